/* hdl/ps2_mouse_packet_tracker_core_defines.svh */
// Assertion macros used by the checker file of the mouse tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define PMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmt check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define PMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmt check failed");

`endif

/* hdl/pmt_pkg.sv */
package pmt_pkg;

  // Header byte layout.
  localparam int unsigned HDR_LEFT    = 0;
  localparam int unsigned HDR_RIGHT   = 1;
  localparam int unsigned HDR_MIDDLE  = 2;
  localparam int unsigned HDR_SYNC    = 3;
  localparam int unsigned HDR_X_SIGN  = 4;
  localparam int unsigned HDR_Y_SIGN  = 5;
  localparam int unsigned HDR_X_OVF   = 6;
  localparam int unsigned HDR_Y_OVF   = 7;

  // Extra travel applied when an overflow bit is set.
  localparam logic signed [9:0] OVF_EXTRA = 10'sd255;

  // Configuration register indexes.
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam int unsigned DIM_BITS = 13;
  localparam int unsigned OUT_BITS = 12;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd1080;

  // Packet byte phase codes.
  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_X   = 2'd1;
  localparam logic [1:0] PH_Y   = 2'd2;

  typedef logic [DIM_BITS-1:0] dim_t;

endpackage

/* hdl/ps2_mouse_packet_tracker_core.sv */
// PS/2 mouse packet tracker. Mouse bytes enter on the s_ stream; the first
// byte after reset is dropped, packets start on a byte with bit 3 set, and
// every third packet byte produces one m_ word carrying the clamped cursor
// position (Y grows downward) and the three buttons. A byte is held in the
// input register; when it moves on, its packet is folded into the cursor and
// the result word is loaded into the output register. The block accepts one
// byte every cycle unless the held byte completes a packet while an earlier
// result still waits, unaccepted, in the output register. Screen width and
// height are written on the cfg_ port; the user must do so only while the
// stream is idle, which the block does not enforce.
module ps2_mouse_packet_tracker_core import pmt_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] pos_x, [23:12] pos_y, [24] left_pressed, [25] right_pressed,
  // [26] middle_pressed, [31:27] zero
  output logic [31:0] m_tdata
);

  dim_t                  screen_width;
  dim_t                  screen_height;
  logic                  skip_first;
  logic [1:0]            byte_phase;
  logic [7:0]            header_byte;
  logic [7:0]            x_delta_byte;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_result;
  logic                  in_fire;
  logic [COORD_BITS-1:0] cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  // The held byte completes a packet; it may move on unless a result is stuck.
  assign in_result = in_valid && !skip_first && (byte_phase == PH_Y);
  assign in_fire   = in_valid && (!in_result || !m_tvalid || m_tready);
  assign s_tready  = !in_valid || in_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // New cursor values for a completed packet.
  pmt_axis #(.COORD_BITS(COORD_BITS), .SUBTRACT(1'b0)) u_axis_x (
    .cur (cursor_x),
    .low (x_delta_byte),
    .neg (header_byte[HDR_X_SIGN]),
    .ovf (header_byte[HDR_X_OVF]),
    .dim (screen_width),
    .nxt (cursor_x_next)
  );

  pmt_axis #(.COORD_BITS(COORD_BITS), .SUBTRACT(1'b1)) u_axis_y (
    .cur (cursor_y),
    .low (in_byte),
    .neg (header_byte[HDR_Y_SIGN]),
    .ovf (header_byte[HDR_Y_OVF]),
    .dim (screen_height),
    .nxt (cursor_y_next)
  );

  // Packet assembly and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_first <= 1'b1;
      byte_phase <= PH_HDR;
      cursor_x   <= '0;
      cursor_y   <= '0;
    end else if (in_fire) begin
      if (skip_first) begin
        skip_first <= 1'b0;
      end else begin
        case (byte_phase)
          PH_X: begin
            byte_phase <= PH_Y;
          end
          PH_Y: begin
            byte_phase <= PH_HDR;
            cursor_x   <= cursor_x_next;
            cursor_y   <= cursor_y_next;
          end
          default: begin
            byte_phase <= in_byte[HDR_SYNC] ? PH_X : PH_HDR;
          end
        endcase
      end
    end
  end

  // Header and X bytes are only captured, so they need no reset.
  always_ff @(posedge clk) begin
    if (in_fire && !skip_first) begin
      if (byte_phase == PH_X) begin
        x_delta_byte <= in_byte;
      end else if (byte_phase != PH_Y && in_byte[HDR_SYNC]) begin
        header_byte <= in_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && in_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (in_fire && in_result) begin
      m_tdata <= {5'b00000,
                  header_byte[HDR_MIDDLE],
                  header_byte[HDR_RIGHT],
                  header_byte[HDR_LEFT],
                  OUT_BITS'(cursor_y_next),
                  OUT_BITS'(cursor_x_next)};
    end
  end

endmodule

/* hdl/pmt_axis.sv */
// One cursor axis: forms the movement from its byte and header bits, applies it
// and clamps the result to the screen dimension.
module pmt_axis import pmt_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter bit SUBTRACT   = 1'b0
) (
  input  logic [COORD_BITS-1:0] cur,
  input  logic [7:0]            low,
  input  logic                  neg,
  input  logic                  ovf,
  input  dim_t                  dim,
  output logic [COORD_BITS-1:0] nxt
);

  localparam int SW = COORD_BITS + 3;
  localparam int LW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam logic [LW-1:0] CAP_W = LW'((1 << COORD_BITS) - 1);

  logic signed [9:0]    d9;
  logic signed [9:0]    delta;
  logic [LW-1:0]        dim_m1;
  logic [COORD_BITS-1:0] lim;
  logic signed [SW-1:0] cur_s;
  logic signed [SW-1:0] lim_s;
  logic signed [SW-1:0] sum;

  // Nine-bit two's complement movement plus overflow travel.
  assign d9    = $signed({neg, neg, low});
  assign delta = ovf ? (neg ? d9 - OVF_EXTRA : d9 + OVF_EXTRA) : d9;

  // Largest coordinate: dimension minus one, zero for an empty dimension,
  // saturated to what the coordinate register can hold.
  always_comb begin
    dim_m1 = (dim == '0) ? '0 : LW'(dim) - LW'(1);
    lim    = (dim_m1 > CAP_W) ? CAP_W[COORD_BITS-1:0] : dim_m1[COORD_BITS-1:0];
  end

  assign cur_s = $signed({3'b000, cur});
  assign lim_s = $signed({3'b000, lim});
  assign sum   = SUBTRACT ? cur_s - SW'(delta) : cur_s + SW'(delta);

  // Clamp into 0..lim.
  always_comb begin
    if (sum < 0) begin
      nxt = '0;
    end else if (sum > lim_s) begin
      nxt = lim;
    end else begin
      nxt = sum[COORD_BITS-1:0];
    end
  end

endmodule

/* hdl/pmt_checker.sv */
`include "ps2_mouse_packet_tracker_core_defines.svh"

// Port-level checks for the mouse tracker.
module pmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result word holds.
  `PMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Nothing is shown right after reset.
  `PMT_ASSERT_NOW(a_reset_empty, $fell(rst), !m_tvalid)

  // Unused result bits stay zero.
  `PMT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[31:27] == 5'b00000)

  // With the output register empty the input side never stalls.
  `PMT_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready)

endmodule

bind ps2_mouse_packet_tracker_core pmt_checker u_pmt_checker (.*);
